>>> src/assert_macros.svh
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is held.
`define AKB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked across reset.
`define AKB_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

>>> src/akb_pkg.sv
// Shared types and constants for the alpha-keyed blit and glyph renderer.
package akb_pkg;

    localparam int GLYPH_WIDTH  = 8;
    localparam int GLYPH_HEIGHT = 16;
    localparam int GL_W         = $clog2(GLYPH_HEIGHT);
    localparam int COL_W        = $clog2(GLYPH_WIDTH);
    localparam int COORD_W      = 16;
    localparam int ADDR_W       = 25;
    localparam int COLOR_W      = 32;
    localparam int CFG_IDX_W    = 3;

    typedef enum logic [1:0] {
        KIND_PIXEL   = 2'd0,
        KIND_GLYPH   = 2'd1,
        KIND_NEWLINE = 2'd2,
        KIND_BEGIN   = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X      = 3'd0,
        REG_ORIGIN_Y      = 3'd1,
        REG_IMAGE_WIDTH   = 3'd2,
        REG_IMAGE_HEIGHT  = 3'd3,
        REG_SCREEN_WIDTH  = 3'd4,
        REG_SCREEN_HEIGHT = 3'd5,
        REG_ROW_STRIDE    = 3'd6,
        REG_DRAW_COLOR    = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic [12:0]        origin_x;
        logic [12:0]        origin_y;
        logic [12:0]        image_width;
        logic [12:0]        image_height;
        logic [11:0]        screen_width;
        logic [11:0]        screen_height;
        logic [12:0]        row_stride;
        logic [COLOR_W-1:0] draw_color;
    } t_cfg;

    // Clipped span: screen row, first column, per-column write mask (MSB = leftmost)
    typedef struct packed {
        logic [11:0]            y;
        logic [11:0]            x_base;
        logic [GLYPH_WIDTH-1:0] mask;
        logic [COLOR_W-1:0]     color;
    } t_span;

    typedef struct packed {
        logic [ADDR_W-1:0]      row_base;
        logic [11:0]            x_base;
        logic [GLYPH_WIDTH-1:0] mask;
        logic [COLOR_W-1:0]     color;
    } t_row;

endpackage

>>> src/akb_front.sv
// Cursor state, coordinate generation and screen clipping; first pipeline register.
module akb_front import akb_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_valid,
    input  logic [1:0]             i_kind,
    input  logic [COLOR_W-1:0]     i_pixel_word,
    input  logic [GLYPH_WIDTH-1:0] i_glyph_row,
    input  logic                   i_down_rdy,
    output logic                   o_rdy,
    output logic                   o_vld,
    output t_span                  o_span
);

    localparam logic [GL_W:0] GLYPH_H_L = (GL_W+1)'(GLYPH_HEIGHT);

    logic [12:0]     r_col, r_row, r_pen_x, r_pen_y;
    logic [GL_W-1:0] r_gl;
    logic [12:0]     n_col, n_row, n_pen_x, n_pen_y;
    logic [GL_W-1:0] n_gl;
    logic            r_vld;
    t_span           r_span, n_span;

    logic            accept;
    t_kind           kind;
    logic [COORD_W-1:0] ox, oy, img_x, img_y, gly_y, gly_xb;
    logic [13:0]     col_inc;
    logic [GL_W:0]   gl_inc;
    logic            img_live;

    function automatic logic on_screen(input logic [COORD_W-1:0] v, input logic [11:0] lim);
        on_screen = !v[COORD_W-1] && (v < {{(COORD_W-12){1'b0}}, lim});
    endfunction

    assign kind   = t_kind'(i_kind);
    assign o_rdy  = !r_vld || i_down_rdy;
    assign accept = i_valid && o_rdy;

    assign ox     = {{(COORD_W-13){i_cfg.origin_x[12]}}, i_cfg.origin_x};
    assign oy     = {{(COORD_W-13){i_cfg.origin_y[12]}}, i_cfg.origin_y};
    assign img_x  = ox + {{(COORD_W-13){1'b0}}, r_col};
    assign img_y  = oy + {{(COORD_W-13){1'b0}}, r_row};
    assign gly_xb = ox + {{(COORD_W-13){1'b0}}, r_pen_x};
    assign gly_y  = oy + {{(COORD_W-13){1'b0}}, r_pen_y} + {{(COORD_W-GL_W){1'b0}}, r_gl};

    assign img_live = r_row < i_cfg.image_height;
    assign col_inc  = {1'b0, r_col} + 14'd1;
    assign gl_inc   = {1'b0, r_gl} + 1'b1;

    // cursor update and span build
    always_comb begin
        logic [COORD_W-1:0] xc;
        n_col   = r_col;
        n_row   = r_row;
        n_gl    = r_gl;
        n_pen_x = r_pen_x;
        n_pen_y = r_pen_y;
        n_span        = '0;
        n_span.color  = i_cfg.draw_color;
        n_span.y      = gly_y[11:0];
        n_span.x_base = gly_xb[11:0];
        case (kind)
            KIND_PIXEL: begin
                n_span.y      = img_y[11:0];
                n_span.x_base = img_x[11:0];
                n_span.color  = {8'h00, i_pixel_word[23:0]};
                n_span.mask[GLYPH_WIDTH-1] = img_live && (i_pixel_word[31:24] != 8'h00)
                    && on_screen(img_x, i_cfg.screen_width)
                    && on_screen(img_y, i_cfg.screen_height);
                if (img_live) begin
                    // width zero acts as width one
                    if (col_inc >= {1'b0, i_cfg.image_width}) begin
                        n_col = '0;
                        n_row = r_row + 13'd1;
                    end else begin
                        n_col = col_inc[12:0];
                    end
                end
            end
            KIND_GLYPH: begin
                for (int c = 0; c < GLYPH_WIDTH; c++) begin
                    xc = gly_xb + COORD_W'(c);
                    n_span.mask[GLYPH_WIDTH-1-c] = i_glyph_row[GLYPH_WIDTH-1-c]
                        && on_screen(xc, i_cfg.screen_width)
                        && on_screen(gly_y, i_cfg.screen_height);
                end
                if (gl_inc >= GLYPH_H_L) begin
                    n_gl    = '0;
                    n_pen_x = r_pen_x + 13'(GLYPH_WIDTH);
                end else begin
                    n_gl = gl_inc[GL_W-1:0];
                end
            end
            KIND_NEWLINE: begin
                n_pen_x = '0;
                n_pen_y = r_pen_y + 13'(GLYPH_HEIGHT);
                n_gl    = '0;
            end
            default: begin
                n_col   = '0;
                n_row   = '0;
                n_gl    = '0;
                n_pen_x = '0;
                n_pen_y = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_gl    <= '0;
            r_pen_x <= '0;
            r_pen_y <= '0;
            r_vld   <= 1'b0;
        end else begin
            if (accept) begin
                r_col   <= n_col;
                r_row   <= n_row;
                r_gl    <= n_gl;
                r_pen_x <= n_pen_x;
                r_pen_y <= n_pen_y;
            end
            // words with nothing to draw never enter the pipe
            if (o_rdy) begin
                r_vld <= accept && (n_span.mask != '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_span <= n_span;
        end
    end

    assign o_vld  = r_vld;
    assign o_span = r_span;

endmodule

>>> src/akb_row_mul.sv
// Row base address stage: screen row times framebuffer stride.
module akb_row_mul import akb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  t_span       i_span,
    input  logic [12:0] i_stride,
    input  logic        i_down_rdy,
    output logic        o_rdy,
    output logic        o_vld,
    output t_row        o_row
);

    logic              r_vld;
    t_row              r_row;
    logic [ADDR_W-1:0] prod;

    assign o_rdy = !r_vld || i_down_rdy;
    assign prod  = {{(ADDR_W-12){1'b0}}, i_span.y} * {{(ADDR_W-13){1'b0}}, i_stride};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_row.row_base <= prod;
            r_row.x_base   <= i_span.x_base;
            r_row.mask     <= i_span.mask;
            r_row.color    <= i_span.color;
        end
    end

    assign o_vld = r_vld;
    assign o_row = r_row;

endmodule

>>> src/akb_expand.sv
// Mask expander: one write per cycle unless stalled, leftmost column first, into the output reg.
module akb_expand import akb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  t_row               i_row,
    input  logic               i_out_stall,
    output logic               o_rdy,
    output logic               o_valid,
    output logic [ADDR_W-1:0]  o_write_address,
    output logic [COLOR_W-1:0] o_write_color,
    output logic               o_last_write
);

    logic                   r_vld;
    t_row                   r_row;
    logic                   r_o_vld;
    logic [ADDR_W-1:0]      r_o_addr;
    logic [COLOR_W-1:0]     r_o_color;
    logic                   r_o_last;

    logic [COL_W-1:0]       lead;
    logic [GLYPH_WIDTH-1:0] rest;
    logic [11:0]            x;
    logic                   out_rdy, emit, done;

    // leftmost set column
    always_comb begin
        logic found;
        found = 1'b0;
        lead  = '0;
        for (int c = 0; c < GLYPH_WIDTH; c++) begin
            if (!found && r_row.mask[GLYPH_WIDTH-1-c]) begin
                lead  = COL_W'(c);
                found = 1'b1;
            end
        end
    end

    assign rest    = r_row.mask & ~({{(GLYPH_WIDTH-1){1'b0}}, 1'b1} << (GLYPH_WIDTH-1-int'(lead)));
    assign x       = r_row.x_base + {{(12-COL_W){1'b0}}, lead};
    assign out_rdy = !r_o_vld || !i_out_stall;
    assign emit    = r_vld && out_rdy;
    assign done    = emit && (rest == '0);
    assign o_rdy   = !r_vld || done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (o_rdy) begin
                r_vld <= i_vld;
            end
            if (out_rdy) begin
                r_o_vld <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_row <= i_row;
        end else if (emit) begin
            r_row.mask <= rest;
        end
        if (emit) begin
            r_o_addr  <= r_row.row_base + {{(ADDR_W-12){1'b0}}, x};
            r_o_color <= r_row.color;
            r_o_last  <= (rest == '0);
        end
    end

    assign o_valid         = r_o_vld;
    assign o_write_address = r_o_addr;
    assign o_write_color   = r_o_color;
    assign o_last_write    = r_o_last;

endmodule

>>> src/alpha_key_blit_and_glyph_render.sv
// Top level of the alpha-keyed blit and monochrome glyph renderer.
// Turns a stream of drawing words into clipped framebuffer writes. A pixel word
// (kind 0) lands at origin plus the running image column/row and is written with
// its low 24 bits unless its alpha byte is zero; a glyph word (kind 1) writes
// draw_color at each set bit, leftmost first, on the current pen line; a newline
// (kind 2) returns the pen to the origin column one glyph height lower; begin
// (kind 3) clears every cursor. Writes off screen are dropped, the address is
// y * row_stride + x, and o_last_write marks the final write of a word.
// Rate: pixel, newline and begin words are taken one per cycle unless the pipe
// backs up. A glyph word holds the mask expander for one write per visible bit,
// so glyph rows stall the input only while their writes drain. Words that produce
// no write never enter the pipe. The first write passes the clip stage, the
// row-multiply stage, and the expander's row register and output register.
// The user must write configuration only while idle; the block does not enforce it; o_cfg_ready is always high.
module alpha_key_blit_and_glyph_render import akb_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // drawing word in
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [1:0]             i_kind,
    input  logic [COLOR_W-1:0]     i_pixel_word,
    input  logic [GLYPH_WIDTH-1:0] i_glyph_row,
    // framebuffer write out
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [ADDR_W-1:0]      o_write_address,
    output logic [COLOR_W-1:0]     o_write_color,
    output logic                   o_last_write,
    // register writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]            i_cfg_data
);

    t_cfg  r_cfg;
    logic  front_rdy, front_vld, mul_rdy, mul_vld, exp_rdy;
    t_span front_span;
    t_row  mul_row;

    assign o_cfg_ready = 1'b1;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x      <= '0;
            r_cfg.origin_y      <= '0;
            r_cfg.image_width   <= 13'd1;
            r_cfg.image_height  <= '0;
            r_cfg.screen_width  <= '0;
            r_cfg.screen_height <= '0;
            r_cfg.row_stride    <= '0;
            r_cfg.draw_color    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_ORIGIN_X:      r_cfg.origin_x      <= i_cfg_data[12:0];
                REG_ORIGIN_Y:      r_cfg.origin_y      <= i_cfg_data[12:0];
                REG_IMAGE_WIDTH:   r_cfg.image_width   <= i_cfg_data[12:0];
                REG_IMAGE_HEIGHT:  r_cfg.image_height  <= i_cfg_data[12:0];
                REG_SCREEN_WIDTH:  r_cfg.screen_width  <= i_cfg_data[11:0];
                REG_SCREEN_HEIGHT: r_cfg.screen_height <= i_cfg_data[11:0];
                REG_ROW_STRIDE:    r_cfg.row_stride    <= i_cfg_data[12:0];
                REG_DRAW_COLOR:    r_cfg.draw_color    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input stalls when the first stage cannot move on
    assign o_stall = !front_rdy;

    akb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_valid),
        .i_kind      (i_kind),
        .i_pixel_word(i_pixel_word),
        .i_glyph_row (i_glyph_row),
        .i_down_rdy  (mul_rdy),
        .o_rdy       (front_rdy),
        .o_vld       (front_vld),
        .o_span      (front_span)
    );

    akb_row_mul u_row_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (front_vld),
        .i_span    (front_span),
        .i_stride  (r_cfg.row_stride),
        .i_down_rdy(exp_rdy),
        .o_rdy     (mul_rdy),
        .o_vld     (mul_vld),
        .o_row     (mul_row)
    );

    akb_expand u_expand (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_vld          (mul_vld),
        .i_row          (mul_row),
        .i_out_stall    (i_stall),
        .o_rdy          (exp_rdy),
        .o_valid        (o_valid),
        .o_write_address(o_write_address),
        .o_write_color  (o_write_color),
        .o_last_write   (o_last_write)
    );

endmodule

>>> src/akb_checker.sv
// Port-level checker for the renderer, bound to the top level.
`include "assert_macros.svh"

module akb_checker import akb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_stall,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic [ADDR_W-1:0]  o_write_address,
    input  logic [COLOR_W-1:0] o_write_color,
    input  logic               o_last_write
);

    // stalled write word holds
    `AKB_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid && $stable(o_write_address) && $stable(o_write_color) && $stable(o_last_write), "stalled write changed")

    // writes of one word come back to back when the sink keeps taking them
    `AKB_ASSERT(a_burst_gapless, o_valid && !i_stall && !o_last_write |=> o_valid, "gap inside a write burst")

    // pipe comes out of reset empty and ready
    `AKB_ASSERT_RST(a_reset_empty, $past(!i_rst_n) |-> !o_valid && !o_stall, "not empty after reset")

endmodule

bind alpha_key_blit_and_glyph_render akb_checker u_akb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_write_address(o_write_address),
    .o_write_color  (o_write_color),
    .o_last_write   (o_last_write)
);

>>> bench/fb_write_checker.sv
// Checker for the blit/glyph renderer: predicts framebuffer writes and compares them.
`timescale 1ns / 100ps

module fb_write_checker import akb_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // drawing word channel
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic [1:0]             i_kind,
    input  logic [COLOR_W-1:0]     i_pixel_word,
    input  logic [GLYPH_WIDTH-1:0] i_glyph_row,
    // framebuffer write channel
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic [ADDR_W-1:0]      i_write_address,
    input  logic [COLOR_W-1:0]     i_write_color,
    input  logic                   i_last_write,
    // register writes
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]            i_cfg_data,
    output int                     o_mismatch_count,
    output int                     o_writes_due
);

    typedef struct packed {
        logic [ADDR_W-1:0]  address;
        logic [COLOR_W-1:0] color;
        logic               last;
    } fb_write_t;

    // register copies
    logic [12:0]        org_x, org_y, img_w, img_h, stride;
    logic [11:0]        scr_w, scr_h;
    logic [COLOR_W-1:0] ink;

    // cursors
    logic [12:0] img_col, img_row, pen_x, pen_y;
    int          glyph_line;

    fb_write_t writes_due[$];
    fb_write_t word_writes[$];
    int        mismatches = 0;

    assign o_mismatch_count = mismatches;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t ns: write mismatch on %s, got %h want %h", $time, what, got, want);
        mismatches++;
    endtask

    // Off-screen writes are simply dropped.
    function automatic void clip_write(int x, int y, logic [COLOR_W-1:0] color);
        fb_write_t w;
        if (x < 0 || y < 0 || x >= int'(scr_w) || y >= int'(scr_h)) return;
        w.address = ADDR_W'(y * int'(stride) + x);
        w.color   = color;
        w.last    = 1'b0;
        word_writes.push_back(w);
    endfunction

    always @(posedge i_clk) begin : watch
        fb_write_t got, want;
        int        ox, oy, gy;
        if (!i_rst_n) begin
            org_x = '0; org_y = '0; img_w = 13'd1; img_h = '0;
            scr_w = '0; scr_h = '0; stride = '0; ink = '0;
            img_col = '0; img_row = '0; pen_x = '0; pen_y = '0;
            glyph_line = 0;
            writes_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = {i_write_address, i_write_color, i_last_write};
                if (writes_due.size() == 0) begin
                    report_mismatch("write with none due", 32'(got.address), '0);
                end else begin
                    want = writes_due.pop_front();
                    if (got.address !== want.address)
                        report_mismatch("address", 32'(got.address), 32'(want.address));
                    if (got.color !== want.color)
                        report_mismatch("color", got.color, want.color);
                    if (got.last !== want.last)
                        report_mismatch("last flag", 32'(got.last), 32'(want.last));
                end
            end

            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_ORIGIN_X:      org_x  = i_cfg_data[12:0];
                    REG_ORIGIN_Y:      org_y  = i_cfg_data[12:0];
                    REG_IMAGE_WIDTH:   img_w  = i_cfg_data[12:0];
                    REG_IMAGE_HEIGHT:  img_h  = i_cfg_data[12:0];
                    REG_SCREEN_WIDTH:  scr_w  = i_cfg_data[11:0];
                    REG_SCREEN_HEIGHT: scr_h  = i_cfg_data[11:0];
                    REG_ROW_STRIDE:    stride = i_cfg_data[12:0];
                    REG_DRAW_COLOR:    ink    = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_in_valid && !i_in_stall) begin
                ox = $signed(org_x);
                oy = $signed(org_y);
                word_writes.delete();
                case (t_kind'(i_kind))
                    KIND_PIXEL: begin
                        // cursor holds once the image is complete
                        if (img_row < img_h) begin
                            if (i_pixel_word[31:24] != 8'h00)
                                clip_write(ox + int'(img_col), oy + int'(img_row),
                                           {8'h00, i_pixel_word[23:0]});
                            // width zero acts as width one
                            if (int'(img_col) + 1 >= int'(img_w)) begin
                                img_col = '0;
                                img_row = img_row + 13'd1;
                            end else begin
                                img_col = img_col + 13'd1;
                            end
                        end
                    end
                    KIND_GLYPH: begin
                        gy = oy + int'(pen_y) + glyph_line;
                        for (int col = 0; col < GLYPH_WIDTH; col++)
                            if (i_glyph_row[GLYPH_WIDTH-1-col])
                                clip_write(ox + int'(pen_x) + col, gy, ink);
                        glyph_line++;
                        if (glyph_line >= GLYPH_HEIGHT) begin
                            glyph_line = 0;
                            pen_x = pen_x + 13'(GLYPH_WIDTH);
                        end
                    end
                    KIND_NEWLINE: begin
                        pen_x = '0;
                        pen_y = pen_y + 13'(GLYPH_HEIGHT);
                        glyph_line = 0;
                    end
                    default: begin
                        img_col = '0; img_row = '0; pen_x = '0; pen_y = '0;
                        glyph_line = 0;
                    end
                endcase
                if (word_writes.size() > 0) begin
                    word_writes[word_writes.size()-1].last = 1'b1;
                    foreach (word_writes[i]) writes_due.push_back(word_writes[i]);
                end
            end
        end
        o_writes_due <= writes_due.size();
    end

endmodule

>>> bench/alpha_key_blit_and_glyph_render_tb.sv
// Testbench top for the blit/glyph renderer: stimulus, back-pressure, watchdog and verdict.
`timescale 1ns / 100ps

module alpha_key_blit_and_glyph_render_tb import akb_pkg::*;;

    localparam int CLK_HALF       = 6;
    // extra slack once no writes are due; leave some margin
    localparam int DRAIN_CYCLES   = 8;
    // longest legal silence is the receiver hold-off below; allow ten times that
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic [1:0]             i_kind = '0;
    logic [COLOR_W-1:0]     i_pixel_word = '0;
    logic [GLYPH_WIDTH-1:0] i_glyph_row = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic [ADDR_W-1:0]      o_write_address;
    logic [COLOR_W-1:0]     o_write_color;
    logic                   o_last_write;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [31:0]            i_cfg_data = '0;

    int mismatch_count;
    int writes_due;
    int quiet_cycles = 0;

    // calm: no random gaps on either side; hold_req: receiver holds off once
    bit calm = 1'b0;
    bit hold_req = 1'b0;

    always #(CLK_HALF) i_clk = ~i_clk;

    alpha_key_blit_and_glyph_render u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_kind          (i_kind),
        .i_pixel_word    (i_pixel_word),
        .i_glyph_row     (i_glyph_row),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_write_address (o_write_address),
        .o_write_color   (o_write_color),
        .o_last_write    (o_last_write),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    fb_write_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_kind           (i_kind),
        .i_pixel_word     (i_pixel_word),
        .i_glyph_row      (i_glyph_row),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_write_address  (o_write_address),
        .i_write_color    (o_write_color),
        .i_last_write     (o_last_write),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_mismatch_count (mismatch_count),
        .o_writes_due     (writes_due)
    );

    // Framebuffer side: random stall ~13% of cycles, none while calm.
    // One long hold-off on request so the pipe backs up into the input.
    initial begin : fb_side
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            i_stall <= (hold_left > 0) || (!calm && $urandom_range(99) < 13);
            if (hold_left > 0) hold_left--;
        end
    end

    // Watchdog: too many cycles with no word moving on any channel.
    always @(posedge i_clk) begin : watchdog
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Keep the low bits of a register value, fill the unused high bits with noise.
    function automatic logic [31:0] with_noise(int value, int width);
        logic [31:0] keep;
        keep = (32'h1 << width) - 32'h1;
        return ($urandom() & ~keep) | (32'(value) & keep);
    endfunction

    task automatic write_reg(t_cfg_reg idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Full register set; only called while the block is idle.
    task automatic load_settings(int ox, int oy, int iw, int ih, int sw, int sh,
                                 int stride, logic [31:0] color);
        write_reg(REG_ORIGIN_X, with_noise(ox, 13));
        write_reg(REG_ORIGIN_Y, with_noise(oy, 13));
        write_reg(REG_IMAGE_WIDTH, with_noise(iw, 13));
        write_reg(REG_IMAGE_HEIGHT, with_noise(ih, 13));
        write_reg(REG_SCREEN_WIDTH, with_noise(sw, 12));
        write_reg(REG_SCREEN_HEIGHT, with_noise(sh, 12));
        write_reg(REG_ROW_STRIDE, with_noise(stride, 13));
        write_reg(REG_DRAW_COLOR, color);
        i_cfg_valid <= 1'b0;
    endtask

    // Small screen around a small origin so most words land somewhere visible.
    task automatic random_settings();
        load_settings(int'($urandom_range(16)) - 8, int'($urandom_range(16)) - 8,
                      $urandom_range(12, 1), $urandom_range(24, 1),
                      $urandom_range(48, 8), $urandom_range(48, 8),
                      $urandom_range(8191), $urandom());
    endtask

    // Offer one drawing word, with optional idle cycles ahead of it.
    task automatic send_word(t_kind kind, logic [31:0] pix, logic [7:0] bits);
        while (!calm && $urandom_range(99) < 13) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_kind       <= kind;
        i_pixel_word <= pix;
        i_glyph_row  <= bits;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Mostly pixels and glyph rows; zero alpha now and then, rare newline/begin.
    task automatic random_words(int count);
        int         pick;
        logic [7:0] alpha;
        repeat (count) begin
            pick  = $urandom_range(99);
            alpha = ($urandom_range(99) < 15) ? 8'h00 : 8'($urandom_range(255, 1));
            if (pick < 50)
                send_word(KIND_PIXEL, {alpha, 24'($urandom())}, 8'($urandom()));
            else if (pick < 90)
                send_word(KIND_GLYPH, $urandom(), 8'($urandom()));
            else if (pick < 96)
                send_word(KIND_NEWLINE, $urandom(), 8'($urandom()));
            else
                send_word(KIND_BEGIN, $urandom(), 8'($urandom()));
        end
    endtask

    // Stop offering and wait until every predicted write has come out.
    task automatic settle(int slack);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (writes_due != 0) @(posedge i_clk);
        repeat (slack) @(posedge i_clk);
    endtask

    initial begin : stimulus
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: 2x2 image at (2,1), small screen.
        load_settings(2, 1, 2, 2, 32, 20, 40, 32'hDEAD_BEEF);
        send_word(KIND_BEGIN, $urandom(), 8'($urandom()));
        send_word(KIND_PIXEL, 32'hFF12_3456, 8'($urandom()));
        send_word(KIND_PIXEL, 32'h00AB_CDEF, 8'($urandom()));   // zero alpha, still steps
        send_word(KIND_PIXEL, 32'hFFFF_FFFF, 8'($urandom()));
        send_word(KIND_PIXEL, 32'h0000_0000, 8'($urandom()));   // ends the last row
        send_word(KIND_PIXEL, 32'h80FE_DCBA, 8'($urandom()));   // image done, dropped
        send_word(KIND_BEGIN, $urandom(), 8'($urandom()));
        send_word(KIND_PIXEL, 32'h0100_0000, 8'($urandom()));
        send_word(KIND_GLYPH, $urandom(), 8'hFF);
        send_word(KIND_GLYPH, $urandom(), 8'h00);
        send_word(KIND_GLYPH, $urandom(), 8'h80);
        send_word(KIND_GLYPH, $urandom(), 8'h01);
        send_word(KIND_GLYPH, $urandom(), 8'hA5);
        send_word(KIND_NEWLINE, $urandom(), 8'($urandom()));    // mid glyph
        send_word(KIND_GLYPH, $urandom(), 8'h5A);
        send_word(KIND_GLYPH, $urandom(), 8'h81);
        send_word(KIND_NEWLINE, $urandom(), 8'($urandom()));
        send_word(KIND_NEWLINE, $urandom(), 8'($urandom()));
        send_word(KIND_GLYPH, $urandom(), 8'hFF);
        send_word(KIND_BEGIN, $urandom(), 8'($urandom()));
        send_word(KIND_GLYPH, $urandom(), 8'hC3);
        settle(DRAIN_CYCLES);

        // Negative origin and a tiny screen, so many writes fall off screen and are clipped.
        load_settings(-3, -2, 6, 9, 5, 4, 5, 32'h0000_0000);
        random_words(15);
        settle(DRAIN_CYCLES);

        // Upper extremes: wide image, largest screen and stride, addresses near the top.
        load_settings(4088, 4094, 4096, 4096, 4095, 4095, 8191, 32'hFFFF_FFFF);
        random_words(12);
        settle(DRAIN_CYCLES);

        // Zero image width behaves as width one, zero stride.
        load_settings(0, -4, 0, 40, 10, 30, 0, $urandom());
        random_words(15);
        settle(DRAIN_CYCLES);

        // Lower extremes: everything off screen, nothing written.
        load_settings(-4096, -4096, 1, 0, 0, 0, 0, 32'h0000_0000);
        random_words(6);
        settle(DRAIN_CYCLES);

        // Full glyph height moves the pen one cell right, then a newline brings it back.
        load_settings(0, 0, 1, 0, 64, 64, 64, $urandom());
        send_word(KIND_BEGIN, $urandom(), 8'($urandom()));
        repeat (GLYPH_HEIGHT) send_word(KIND_GLYPH, $urandom(), 8'($urandom()));
        send_word(KIND_GLYPH, $urandom(), 8'hFF);
        send_word(KIND_NEWLINE, $urandom(), 8'($urandom()));
        send_word(KIND_GLYPH, $urandom(), 8'h81);
        settle(DRAIN_CYCLES);

        // Random settings; first phase runs with no gaps at all.
        calm = 1'b1;
        random_settings();
        random_words(15);
        settle(DRAIN_CYCLES);
        calm = 1'b0;

        // Receiver holds off while words keep coming, so the input backs up.
        random_settings();
        hold_req = 1'b1;
        random_words(30);
        settle(DRAIN_CYCLES);

        // Sender pauses mid-phase until the pipe is empty.
        random_settings();
        random_words(8);
        settle(0);
        random_words(8);
        settle(DRAIN_CYCLES);

        random_settings();
        random_words(12);
        settle(DRAIN_CYCLES);

        if (mismatch_count == 0 && writes_due == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
